[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is not checked while reset is asserted.
`define GRM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked property that also holds during reset.
`define GRM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/grm_pkg.sv]
package grm_pkg;

    localparam int CHANNELS     = 8;
    localparam int CHANNEL_W    = 3;
    localparam int GAIN_W       = 40;
    localparam int TARGET_W     = 24;
    localparam int LEN_W        = 16;
    localparam int SAMPLE_W     = 24;
    localparam int DEST_W       = 32;
    localparam int THRESH_W     = 23;
    localparam int EPS_W        = 20;
    localparam int CFG_DATA_W   = 23;
    localparam int CFG_INDEX_W  = 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int S_TDATA_W    = 104;
    localparam int M_TDATA_W    = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_EPSILON      = 1'b1;

    localparam logic [THRESH_W-1:0] SILENCE_THRESHOLD_RESET = 23'd16;
    localparam logic [EPS_W-1:0]    RAMP_EPSILON_RESET      = 20'd8192;

    // Operation codes carried in tuser.
    localparam logic OP_MIX  = 1'b0;
    localparam logic OP_RAMP = 1'b1;

    typedef enum logic [1:0] {
        CMD_MIX  = 2'd0,
        CMD_PASS = 2'd1,
        CMD_RAMP = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                    kind;
        logic [CHANNEL_W-1:0]         channel;
        logic signed [TARGET_W-1:0]   target_gain;
        logic [LEN_W-1:0]             ramp_length;
        logic signed [SAMPLE_W-1:0]   sample;
        logic signed [DEST_W-1:0]     dest_in;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/grm_front.sv]
module grm_front
    import grm_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam logic [CHANNEL_W:0] CH_LIMIT = (CHANNEL_W + 1)'(CHANNELS);

    logic in_range;
    logic keep;

    assign s_tready = !q_full;

    always_comb
    begin
        q_cmd.channel     = s_tdata[2:0];
        q_cmd.target_gain = $signed(s_tdata[26:3]);
        q_cmd.ramp_length = s_tdata[42:27];
        q_cmd.sample      = $signed(s_tdata[66:43]);
        q_cmd.dest_in     = $signed(s_tdata[98:67]);
        in_range = {1'b0, q_cmd.channel} < CH_LIMIT;
        keep = 1'b1;
        if (s_tuser == OP_RAMP)
        begin
            q_cmd.kind = CMD_RAMP;
            // A ramp start with no length or on a missing channel has no effect.
            keep = in_range && (q_cmd.ramp_length != '0);
        end
        else if (in_range)
        begin
            q_cmd.kind = CMD_MIX;
        end
        else
        begin
            q_cmd.kind = CMD_PASS;
        end
    end

    assign q_push = s_tvalid && s_tready && keep;

endmodule

[rtl/grm_queue.sv]
module grm_queue
    import grm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic valid,
    input  logic pop,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_DEPTH;
    assign valid   = count_reg != '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/grm_div.sv]
module grm_div
    import grm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [GAIN_W-1:0] dvd_reg, dvd_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  dsr_reg, dsr_next;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;
    logic              ge;

    // Restoring division, one quotient bit per cycle; quotient bits shift
    // into the dividend register as the dividend shifts out.
    assign trial = {rem_reg, dvd_reg[GAIN_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[GAIN_W-2:0], ge};
            rem_next = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

[rtl/grm_back.sv]
module grm_back
    import grm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       q_valid,
    input  cmd_t                       q_head,
    output logic                       q_pop,
    output div_req_t                   div_req,
    input  div_rsp_t                   div_rsp,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic signed [DEST_W-1:0]   dest_out,
    output logic signed [TARGET_W-1:0] gain_now,
    output logic                       ramping
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_ROUND  = 7'b0000100,
        ST_OUT    = 7'b0001000,
        ST_DSTART = 7'b0010000,
        ST_DWAIT  = 7'b0100000,
        ST_STEP   = 7'b1000000
    } back_state_t;

    localparam int LO_W      = 20;
    localparam int PLO_W     = SAMPLE_W + LO_W + 1;
    localparam int PHI_W     = SAMPLE_W + GAIN_W - LO_W;
    localparam int PROD_W    = 64;
    localparam int FRAC_W    = 36;
    localparam int CONTRIB_W = PROD_W - FRAC_W;
    localparam int SUM_W     = DEST_W + 2;
    localparam int NUM_W     = GAIN_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [GAIN_W-1:0] G_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] G_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic signed [DEST_W-1:0] D_MAX = {1'b0, {(DEST_W-1){1'b1}}};
    localparam logic signed [DEST_W-1:0] D_MIN = {1'b1, {(DEST_W-1){1'b0}}};

    back_state_t                state_reg, state_next;
    cmd_t                       cmd_reg, cmd_next;
    logic [THRESH_W-1:0]        thresh_reg;
    logic [EPS_W-1:0]           eps_reg;

    logic signed [GAIN_W-1:0]   gain_reg   [CHANNELS];
    logic signed [GAIN_W-1:0]   step_reg   [CHANNELS];
    logic signed [TARGET_W-1:0] target_reg [CHANNELS];
    logic [LEN_W-1:0]           remain_reg [CHANNELS];

    logic signed [PLO_W-1:0]     prod_lo_reg, prod_lo_next;
    logic signed [PHI_W-1:0]     prod_hi_reg, prod_hi_next;
    logic signed [CONTRIB_W-1:0] contrib_reg, contrib_next;
    logic                        mix_reg, mix_next;
    logic                        ramp_reg, ramp_next;
    logic signed [TARGET_W-1:0]  gnow_reg, gnow_next;
    logic                        neg_reg, neg_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic signed [DEST_W-1:0]    dest_out_reg, dest_out_next;
    logic signed [TARGET_W-1:0]  gain_now_reg;
    logic                        ramping_reg;
    logic                        out_load;

    logic                        mix_wr, ramp_wr;
    logic signed [GAIN_W-1:0]    gain_next, step_next;
    logic [LEN_W-1:0]            remain_next;

    logic [CHANNEL_W-1:0]        ch;
    logic signed [GAIN_W-1:0]    gain_cur;
    logic signed [GAIN_W-1:0]    step_cur;
    logic [LEN_W-1:0]            remain_cur;
    logic signed [NUM_W-1:0]     gain_sum;
    logic signed [NUM_W-1:0]     gain_ext;
    logic signed [NUM_W-1:0]     thresh_ext;
    logic signed [PLO_W-1:0]     lo_a, lo_b;
    logic signed [PHI_W-1:0]     hi_a, hi_b;
    logic signed [PROD_W-1:0]    prod_full;
    logic signed [NUM_W-1:0]     num;
    logic signed [NUM_W-1:0]     q_signed;
    logic signed [GAIN_W-1:0]    step_sat;
    logic signed [NUM_W-1:0]     step_ext;
    logic signed [NUM_W-1:0]     eps_ext;
    logic signed [SUM_W-1:0]     dest_sum;

    assign ch         = cmd_reg.channel;
    assign gain_cur   = gain_reg[ch];
    assign step_cur   = step_reg[ch];
    assign remain_cur = remain_reg[ch];

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        q_pop         = 1'b0;
        prod_lo_next  = prod_lo_reg;
        prod_hi_next  = prod_hi_reg;
        contrib_next  = contrib_reg;
        mix_next      = mix_reg;
        ramp_next     = ramp_reg;
        gnow_next     = gnow_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg;
        dest_out_next = dest_out_reg;
        out_load      = 1'b0;
        mix_wr        = 1'b0;
        ramp_wr       = 1'b0;
        gain_next     = gain_cur;
        step_next     = step_cur;
        remain_next   = remain_cur;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = cmd_reg.ramp_length;

        lo_a       = PLO_W'(cmd_reg.sample);
        lo_b       = $signed({{(PLO_W-LO_W){1'b0}}, gain_cur[LO_W-1:0]});
        hi_a       = PHI_W'(cmd_reg.sample);
        hi_b       = PHI_W'($signed(gain_cur[GAIN_W-1:LO_W]));
        gain_ext   = NUM_W'(gain_cur);
        thresh_ext = $signed({2'b00, thresh_reg, 16'h0000});
        gain_sum   = NUM_W'(gain_cur) + NUM_W'(step_cur);
        prod_full  = $signed({prod_hi_reg, {LO_W{1'b0}}}) + PROD_W'(prod_lo_reg)
                     + ROUND_HALF;
        num        = NUM_W'($signed({cmd_reg.target_gain, 16'h0000})) - gain_ext;
        q_signed   = neg_reg ? -$signed({1'b0, div_rsp.quotient})
                             :  $signed({1'b0, div_rsp.quotient});
        if (q_signed[NUM_W-1] != q_signed[NUM_W-2])
        begin
            step_sat = q_signed[NUM_W-1] ? G_MIN : G_MAX;
        end
        else
        begin
            step_sat = q_signed[GAIN_W-1:0];
        end
        step_ext = NUM_W'(step_sat);
        eps_ext  = $signed({{(NUM_W-EPS_W){1'b0}}, eps_reg});
        dest_sum = SUM_W'(cmd_reg.dest_in) + (mix_reg ? SUM_W'(contrib_reg) : '0);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    unique case (q_head.kind)
                        CMD_MIX:  state_next = ST_MUL;
                        CMD_RAMP: state_next = ST_DSTART;
                        default:
                        begin
                            mix_next   = 1'b0;
                            ramp_next  = 1'b0;
                            gnow_next  = '0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_lo_next = lo_a * lo_b;
                prod_hi_next = hi_a * hi_b;
                gnow_next    = gain_cur[GAIN_W-1:16];
                ramp_next    = remain_cur != '0;
                mix_next     = (remain_cur != '0) || (gain_ext > thresh_ext)
                               || (gain_ext < -thresh_ext);
                if (remain_cur != '0)
                begin
                    mix_wr      = 1'b1;
                    remain_next = remain_cur - 1'b1;
                    if (remain_cur == LEN_W'(1))
                    begin
                        // Last sample of the ramp: land exactly on the target.
                        gain_next = $signed({target_reg[ch], 16'h0000});
                        step_next = '0;
                    end
                    else if (gain_sum[NUM_W-1] != gain_sum[NUM_W-2])
                    begin
                        gain_next = gain_sum[NUM_W-1] ? G_MIN : G_MAX;
                    end
                    else
                    begin
                        gain_next = gain_sum[GAIN_W-1:0];
                    end
                end
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                contrib_next = prod_full[PROD_W-1:FRAC_W];
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    if (dest_sum[SUM_W-1:DEST_W-1] == '0
                        || dest_sum[SUM_W-1:DEST_W-1] == '1)
                    begin
                        dest_out_next = dest_sum[DEST_W-1:0];
                    end
                    else
                    begin
                        dest_out_next = dest_sum[SUM_W-1] ? D_MIN : D_MAX;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_DSTART:
            begin
                neg_next         = num[NUM_W-1];
                div_req.start    = 1'b1;
                div_req.dividend = num[NUM_W-1] ? GAIN_W'(-num) : num[GAIN_W-1:0];
                state_next       = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (step_ext > eps_ext || step_ext < -eps_ext)
                begin
                    ramp_wr     = 1'b1;
                    step_next   = step_sat;
                    remain_next = cmd_reg.ramp_length;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            thresh_reg   <= SILENCE_THRESHOLD_RESET;
            eps_reg      <= RAMP_EPSILON_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                gain_reg[i]   <= '0;
                step_reg[i]   <= '0;
                target_reg[i] <= '0;
                remain_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SILENCE_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                    REG_RAMP_EPSILON:      eps_reg    <= cfg_data[EPS_W-1:0];
                    default:               ;
                endcase
            end
            if (mix_wr)
            begin
                gain_reg[ch]   <= gain_next;
                step_reg[ch]   <= step_next;
                remain_reg[ch] <= remain_next;
            end
            if (ramp_wr)
            begin
                step_reg[ch]   <= step_next;
                target_reg[ch] <= cmd_reg.target_gain;
                remain_reg[ch] <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        contrib_reg <= contrib_next;
        mix_reg     <= mix_next;
        ramp_reg    <= ramp_next;
        gnow_reg    <= gnow_next;
        neg_reg     <= neg_next;
        if (out_load)
        begin
            dest_out_reg <= dest_out_next;
            gain_now_reg <= gnow_reg;
            ramping_reg  <= ramp_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign dest_out = dest_out_reg;
    assign gain_now = gain_now_reg;
    assign ramping  = ramping_reg;

endmodule

[rtl/gain_ramp_channel_mixer_core.sv]
// Channel   Group                          Payload
// input     s_tvalid/s_tready/s_tdata/s_tuser  op in tuser, mix or ramp fields in tdata
// output    m_tvalid/m_tready/m_tdata      one result per mix transfer
// config    cfg_we/cfg_index/cfg_data      silence threshold, ramp epsilon
//
// In the back end a mix transfer goes through dequeue, split multiply, round and output.
// A ramp start computes the gain step with the 40-step serial divider.
// Ramp starts with zero length or an out-of-range channel are absorbed at the input.
// The two-entry command queue lets input transfers continue while a result waits on m_tready.
// Reset is asynchronous and clears all channel gains, steps, targets and ramp counts.
module gain_ramp_channel_mixer_core
    import grm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // channel[2:0], target_gain[26:3], ramp_length[42:27], sample[66:43], dest_in[98:67]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // op
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // dest_out[31:0], gain_now[55:32], ramping[56]
    output logic [M_TDATA_W-1:0]   m_tdata
);

    cmd_t                       push_cmd;
    cmd_t                       head_cmd;
    logic                       q_push;
    logic                       q_full;
    logic                       q_valid;
    logic                       q_pop;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;
    logic signed [DEST_W-1:0]   dest_out;
    logic signed [TARGET_W-1:0] gain_now;
    logic                       ramping;

    grm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    grm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .head     (head_cmd)
    );

    grm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    grm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dest_out  (dest_out),
        .gain_now  (gain_now),
        .ramping   (ramping)
    );

    assign m_tdata = {{(M_TDATA_W - DEST_W - TARGET_W - 1){1'b0}}, ramping, gain_now, dest_out};

endmodule

[rtl/grm_checker.sv]
`include "assert_macros.svh"

module grm_checker
    import grm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PEND_W = 3;
    localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(QUEUE_DEPTH + 2);

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic              mix_in;
    logic              res_out;

    // Mix transfers in flight: every mix transfer yields exactly one result.
    assign mix_in  = s_tvalid && s_tready && (s_tuser == OP_MIX);
    assign res_out = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (mix_in && !res_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (res_out && !mix_in)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `GRM_ASSERT(a_out_held, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `GRM_ASSERT(a_out_stable, clk, rst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    `GRM_ASSERT(a_no_extra, clk, rst_n, m_tvalid |-> pending_reg != '0, "result without a pending mix transfer")
    `GRM_ASSERT(a_pend_bound, clk, rst_n, pending_reg <= PEND_MAX, "more mix transfers in flight than buffers")

endmodule

bind gain_ramp_channel_mixer_core grm_checker u_grm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
